FILE: rtl/core/gasl_pkg.sv
// Shared widths, payload types and microcode for the goal approach speed limiter.
package gasl_pkg;

	localparam int POSITION_WIDTH = 24;
	localparam int SPEED_WIDTH    = 16;
	localparam int DIST_WIDTH     = 16;

	localparam int AXIS_SAT  = 131072;
	localparam int GAP_W     = 18;
	localparam int RAD_W     = 2 * GAP_W;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int NUM_W     = SPEED_WIDTH + DIST_WIDTH;
	localparam int CNT_W     = $clog2(NUM_W);
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);

	typedef enum logic [2:0] {
		REG_GOAL_X   = 3'd0,
		REG_GOAL_Y   = 3'd1,
		REG_GOAL_TOL = 3'd2,
		REG_APPROACH = 3'd3,
		REG_MIN_SPD  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [POSITION_WIDTH-1:0] pos_x;
		logic signed [POSITION_WIDTH-1:0] pos_y;
		logic signed [SPEED_WIDTH-1:0]    speed_in;
		logic signed [SPEED_WIDTH-1:0]    turn_rate_in;
	} tick_t;

	typedef struct packed {
		logic signed [SPEED_WIDTH-1:0] speed_out;
		logic signed [SPEED_WIDTH-1:0] turn_rate_out;
		logic                          reached;
	} result_t;

	typedef enum logic [3:0] {
		OP_FETCH = 4'd0,
		OP_GAP   = 4'd1,
		OP_SQX   = 4'd2,
		OP_SQY   = 4'd3,
		OP_SUM   = 4'd4,
		OP_ROOT  = 4'd5,
		OP_TEST  = 4'd6,
		OP_SCALE = 4'd7,
		OP_DIV   = 4'd8,
		OP_FIX   = 4'd9,
		OP_WRITE = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		C_NEXT = 2'd0,
		C_JUMP = 2'd1,
		C_LOOP = 2'd2,
		C_SKIP = 2'd3
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_FETCH = 4'd0;
	localparam step_t STEP_GAP   = 4'd1;
	localparam step_t STEP_SQX   = 4'd2;
	localparam step_t STEP_SQY   = 4'd3;
	localparam step_t STEP_SUM   = 4'd4;
	localparam step_t STEP_ROOT  = 4'd5;
	localparam step_t STEP_TEST  = 4'd6;
	localparam step_t STEP_SCALE = 4'd7;
	localparam step_t STEP_DIV   = 4'd8;
	localparam step_t STEP_FIX   = 4'd9;
	localparam step_t STEP_WRITE = 4'd10;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic tick_valid;
		logic out_busy;
		logic cnt_zero;
		logic no_zone;
	} seq_status_t;

	function automatic uword_t gasl_rom(step_t pc);
		uword_t w;
		case (pc)
			STEP_FETCH: w = '{OP_FETCH, C_NEXT, STEP_FETCH};
			STEP_GAP:   w = '{OP_GAP,   C_NEXT, STEP_FETCH};
			STEP_SQX:   w = '{OP_SQX,   C_NEXT, STEP_FETCH};
			STEP_SQY:   w = '{OP_SQY,   C_NEXT, STEP_FETCH};
			STEP_SUM:   w = '{OP_SUM,   C_NEXT, STEP_FETCH};
			STEP_ROOT:  w = '{OP_ROOT,  C_LOOP, STEP_ROOT};
			STEP_TEST:  w = '{OP_TEST,  C_SKIP, STEP_WRITE};
			STEP_SCALE: w = '{OP_SCALE, C_NEXT, STEP_FETCH};
			STEP_DIV:   w = '{OP_DIV,   C_LOOP, STEP_DIV};
			STEP_FIX:   w = '{OP_FIX,   C_NEXT, STEP_FETCH};
			STEP_WRITE: w = '{OP_WRITE, C_JUMP, STEP_FETCH};
			default:    w = '{OP_FETCH, C_JUMP, STEP_FETCH};
		endcase
		return w;
	endfunction

	// Absolute axis difference, saturated at AXIS_SAT.
	function automatic logic [GAP_W-1:0] gasl_gap(
		logic [POSITION_WIDTH-1:0] a,
		logic [POSITION_WIDTH-1:0] b
	);
		logic signed [POSITION_WIDTH:0] d;
		logic [POSITION_WIDTH:0]        m;
		logic [63:0]                    m64;
		d   = $signed({a[POSITION_WIDTH-1], a}) - $signed({b[POSITION_WIDTH-1], b});
		m   = d[POSITION_WIDTH] ? (POSITION_WIDTH+1)'(-d) : d;
		m64 = 64'(m);
		if (m64 > 64'(AXIS_SAT))
			return GAP_W'(AXIS_SAT);
		return m64[GAP_W-1:0];
	endfunction

endpackage

FILE: rtl/core/gasl_seq.sv
// Microcode sequencer: step counter, control ROM, stalls and conditional jumps.
module gasl_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gasl_pkg::seq_status_t  status,
	output gasl_pkg::uword_t       ctrl,
	output logic                   fire
);
	import gasl_pkg::*;

	step_t pc_q;
	step_t pc_next;
	logic  stall;

	assign ctrl  = gasl_rom(pc_q);
	assign stall = ((ctrl.op == OP_FETCH) && !status.tick_valid) ||
	               ((ctrl.op == OP_WRITE) && status.out_busy);
	assign fire  = !stall;

	always_comb begin
		case (ctrl.cond)
			C_NEXT:  pc_next = pc_q + step_t'(1);
			C_JUMP:  pc_next = ctrl.target;
			C_LOOP:  pc_next = status.cnt_zero ? pc_q + step_t'(1) : ctrl.target;
			C_SKIP:  pc_next = status.no_zone ? ctrl.target : pc_q + step_t'(1);
			default: pc_next = STEP_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else if (fire) begin
			pc_q <= pc_next;
		end
	end

endmodule

FILE: rtl/core/goal_approach_speed_limiter_core.sv
// Top level of the goal approach speed limiter: APB registers, datapath, result register.
//
// Usage
//   Tick channel (tick_valid/tick_ready/tick) carries one control tick: robot position,
//   requested linear speed and turn rate. Result channel (result_valid/result_ready/result)
//   returns one word per tick: limited speed, the turn rate unchanged and the reached flag.
//   Both handshakes complete on a rising edge with valid and ready high.
//   The APB port holds goal_x, goal_y, goal_tolerance, approach_distance and
//   min_approach_speed at byte addresses 0, 4, 8, 12, 16; write them only while idle.
//   Writing goal_x or goal_y clears the sticky reached flag.
// Timing
//   A microcoded sequencer works on one tick at a time. The square root takes one
//   result bit per cycle and the scaling divide one quotient bit per cycle. Outside
//   the approach zone the scaling and divide steps are skipped, and a new tick is
//   taken only after the word of the last one has been written.
//   tick_ready is high only while the sequencer sits at its fetch step.
// Reset and stalls
//   Reset returns the sequencer to fetch, empties the result register, clears the flag
//   and loads register defaults (tolerance 50, all others zero).
//   A finished word waits in the result register; the next tick is still accepted and
//   worked on, and the sequencer holds at its write step until the register is free.
module goal_approach_speed_limiter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick_valid,
	output logic                       tick_ready,
	input  gasl_pkg::tick_t            tick,
	output logic                       result_valid,
	input  logic                       result_ready,
	output gasl_pkg::result_t          result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gasl_pkg::ADDR_W-1:0] paddr,
	input  logic [gasl_pkg::DATA_W-1:0] pwdata,
	output logic [gasl_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import gasl_pkg::*;

	// Configuration registers, kept at their own widths.
	logic [POSITION_WIDTH-1:0] goal_x_q;
	logic [POSITION_WIDTH-1:0] goal_y_q;
	logic [DIST_WIDTH-1:0]     tol_q;
	logic [DIST_WIDTH-1:0]     appr_q;
	logic [SPEED_WIDTH-1:0]    min_spd_q;
	logic                      reached_q;

	// Datapath registers.
	logic [POSITION_WIDTH-1:0] pos_x_q;
	logic [POSITION_WIDTH-1:0] pos_y_q;
	logic signed [SPEED_WIDTH-1:0] speed_q;
	logic [SPEED_WIDTH-1:0]    turn_q;
	logic [GAP_W-1:0]          gap_x_q;
	logic [GAP_W-1:0]          gap_y_q;
	logic [RAD_W-1:0]          sq_q;
	logic [RAD_W-1:0]          rad_q;
	logic [ROOT_W-1:0]         root_q;
	logic [ROOT_W:0]           rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [SPEED_WIDTH-1:0]    mag_q;
	logic                      neg_q;
	logic [NUM_W-1:0]          num_q;
	logic [DIST_WIDTH-1:0]     div_rem_q;
	logic signed [SPEED_WIDTH-1:0] res_q;
	result_t                   result_q;
	logic                      out_valid_q;

	// Sequencer interface.
	seq_status_t status;
	uword_t      ctrl;
	logic        fire;

	logic                   cfg_wr;
	reg_idx_t               cfg_idx;
	logic                   goal_wr;
	logic                   in_zone;
	logic [ROOT_W+2:0]      rem_sh;
	logic [ROOT_W+2:0]      trial;
	logic [ROOT_W+2:0]      rem_diff;
	logic                   root_take;
	logic [DIST_WIDTH:0]    div_sh;
	logic [DIST_WIDTH:0]    div_diff;
	logic                   div_take;
	logic signed [SPEED_WIDTH-1:0] quot;
	logic signed [SPEED_WIDTH-1:0] scaled;

	gasl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.fire   (fire)
	);

	// Handshakes: take a tick only at the fetch step; the result register frees itself
	// as soon as the receiver takes the word.
	assign tick_ready   = (ctrl.op == OP_FETCH);
	assign result_valid = out_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;

	assign in_zone = (appr_q != '0) && (root_q < ROOT_W'(appr_q));

	assign status.tick_valid = tick_valid;
	assign status.out_busy   = out_valid_q && !result_ready;
	assign status.cnt_zero   = (cnt_q == '0);
	assign status.no_zone    = !in_zone;

	// APB decode: word-aligned registers, writes beyond the list drop.
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign goal_wr = cfg_wr && ((cfg_idx == REG_GOAL_X) || (cfg_idx == REG_GOAL_Y));

	always_comb begin
		case (cfg_idx)
			REG_GOAL_X:   prdata = DATA_W'(goal_x_q);
			REG_GOAL_Y:   prdata = DATA_W'(goal_y_q);
			REG_GOAL_TOL: prdata = DATA_W'(tol_q);
			REG_APPROACH: prdata = DATA_W'(appr_q);
			REG_MIN_SPD:  prdata = DATA_W'(min_spd_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q  <= '0;
			goal_y_q  <= '0;
			tol_q     <= DIST_WIDTH'(50);
			appr_q    <= '0;
			min_spd_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_GOAL_X:   goal_x_q  <= pwdata[POSITION_WIDTH-1:0];
				REG_GOAL_Y:   goal_y_q  <= pwdata[POSITION_WIDTH-1:0];
				REG_GOAL_TOL: tol_q     <= pwdata[DIST_WIDTH-1:0];
				REG_APPROACH: appr_q    <= pwdata[DIST_WIDTH-1:0];
				REG_MIN_SPD:  min_spd_q <= pwdata[SPEED_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sticky reached flag: set at the test step, drop on a goal write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= 1'b0;
		end else if (goal_wr) begin
			reached_q <= 1'b0;
		end else if (fire && (ctrl.op == OP_TEST) && (root_q < ROOT_W'(tol_q))) begin
			reached_q <= 1'b1;
		end
	end

	// Result register: load at the write step, clear when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && (ctrl.op == OP_WRITE)) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Square root step: bring down two radicand bits, try (root << 2) | 1.
	assign rem_sh    = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign rem_diff  = rem_sh - trial;
	assign root_take = (rem_sh >= trial);

	// Restoring divide step: bring down one dividend bit, try the approach distance.
	assign div_sh   = {div_rem_q, num_q[NUM_W-1]};
	assign div_diff = div_sh - {1'b0, appr_q};
	assign div_take = (div_sh >= {1'b0, appr_q});

	// Quotient stays below the speed magnitude, so it fits as a positive value.
	assign quot   = $signed(num_q[SPEED_WIDTH-1:0]);
	assign scaled = neg_q ? -quot : quot;

	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctrl.op)
				OP_FETCH: begin
					pos_x_q <= tick.pos_x;
					pos_y_q <= tick.pos_y;
					speed_q <= tick.speed_in;
					turn_q  <= tick.turn_rate_in;
				end
				OP_GAP: begin
					gap_x_q <= gasl_gap(pos_x_q, goal_x_q);
					gap_y_q <= gasl_gap(pos_y_q, goal_y_q);
				end
				OP_SQX: begin
					sq_q <= gap_x_q * gap_x_q;
				end
				OP_SQY: begin
					rad_q <= sq_q;
					sq_q  <= gap_y_q * gap_y_q;
				end
				OP_SUM: begin
					rad_q  <= rad_q + sq_q;
					root_q <= '0;
					rem_q  <= '0;
					cnt_q  <= ROOT_LAST;
				end
				OP_ROOT: begin
					rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
					root_q <= {root_q[ROOT_W-2:0], root_take};
					rem_q  <= root_take ? rem_diff[ROOT_W:0] : rem_sh[ROOT_W:0];
					cnt_q  <= cnt_q - CNT_W'(1);
				end
				OP_TEST: begin
					res_q <= speed_q;
					neg_q <= speed_q[SPEED_WIDTH-1];
					mag_q <= speed_q[SPEED_WIDTH-1] ? SPEED_WIDTH'(-speed_q)
					                                : SPEED_WIDTH'(speed_q);
				end
				OP_SCALE: begin
					// Distance is below the approach distance here, so 16 bits hold it.
					num_q     <= mag_q * root_q[DIST_WIDTH-1:0];
					div_rem_q <= '0;
					cnt_q     <= DIV_LAST;
				end
				OP_DIV: begin
					div_rem_q <= div_take ? div_diff[DIST_WIDTH-1:0]
					                      : div_sh[DIST_WIDTH-1:0];
					num_q     <= {num_q[NUM_W-2:0], div_take};
					cnt_q     <= cnt_q - CNT_W'(1);
				end
				OP_FIX: begin
					res_q <= (scaled < $signed(min_spd_q)) ? $signed(min_spd_q) : scaled;
				end
				OP_WRITE: begin
					result_q.speed_out     <= res_q;
					result_q.turn_rate_out <= turn_q;
					result_q.reached       <= reached_q;
				end
				default: begin
				end
			endcase
		end
	end

	// A goal write always leaves the flag clear.
	a_goal_clears: assert property (@(posedge clk) disable iff (!arst_n)
		goal_wr |=> !reached_q)
		else $error("reached flag survived a goal write");

	// One tick at a time: after an acceptance the sequencer leaves fetch.
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready) |=> !tick_ready)
		else $error("second tick accepted back to back");

	// The divider remainder stays below the divisor throughout the loop.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DIV) |-> (div_rem_q < appr_q))
		else $error("divider remainder out of range");

	// The result register is only reloaded once its word has gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (ctrl.op == OP_WRITE)) |-> (!out_valid_q || result_ready))
		else $error("result word overwritten before being taken");

endmodule
